// ===== rtl/core/tcbg_pkg.sv =====
package tcbg_pkg;

    // character rom geometry, code*8+line addressing
    localparam int ROM_BYTES = 2048;
    localparam int ROM_AW    = 11;

    // command kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SCREEN_BASE = 2'd0;
    localparam logic [1:0] REG_WIN_START   = 2'd1;
    localparam logic [1:0] REG_WIN_END     = 2'd2;

    // register reset values
    localparam logic [15:0] SCREEN_BASE_RST = 16'hD000;
    localparam logic [9:0]  WIN_START_RST   = 10'd0;
    localparam logic [9:0]  WIN_END_RST     = 10'd512;

    // horizontal visibility window
    typedef struct packed {
        logic [9:0] start_x;
        logic [9:0] end_x;
    } window_t;

endpackage

// ===== rtl/core/tcbg_window_unit.sv =====
module tcbg_window_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic [7:0]          pix_byte,
    input  logic [8:0]          base_x,
    input  tcbg_pkg::window_t   win,
    output logic                done,
    output logic [7:0]          mask
);

    logic       run_reg;
    logic [2:0] step_reg;
    logic       done_reg;
    logic [7:0] byte_reg;
    logic [8:0] base_reg;
    logic [7:0] mask_reg;
    logic [9:0] px;
    logic       hit;

    // one pixel per cycle through a single compare pair
    assign px  = {1'b0, base_reg} + {7'd0, step_reg};
    assign hit = byte_reg[3'd7 - step_reg] && (px >= win.start_x) && (px < win.end_x);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                run_reg  <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= pix_byte;
            base_reg <= base_x;
            mask_reg <= 8'd0;
        end
        else if (run_reg)
        begin
            mask_reg[step_reg] <= hit;
        end
    end

    assign done = done_reg;
    assign mask = mask_reg;

endmodule

// ===== rtl/core/text_character_bitmap_generator_top.sv =====
// character write: busy through the offset check, 8 glyph lines and drain after acceptance,
//   only the offset check when off screen; rom load: written at the accepting edge, no busy
// scanout read: busy until the done strobe, which follows the bitmap read and the
//   serial window unit testing one pixel per cycle
// after reset a clearing pass over max(ROM_BYTES, MAP_BYTES) addresses
//   fills the rom with 0xff and the bitmap with zero while busy is high; results are never stalled
module text_character_bitmap_generator_top #(
    parameter int SCREEN_CELLS = 1024,
    parameter int MAP_BYTES    = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [15:0] cpu_address,
    input  logic [7:0]  char_code,
    input  logic [10:0] rom_index,
    input  logic [7:0]  rom_byte,
    input  logic [12:0] map_index,
    // result channel, one cycle strobe
    output logic        done,
    output logic [7:0]  map_byte,
    output logic [8:0]  pixel_x,
    output logic [6:0]  pixel_y,
    output logic [7:0]  lit_mask,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int MAP_AW = $clog2(MAP_BYTES);
    localparam int OFF_W  = $clog2(SCREEN_CELLS);
    // (offset / 64) * 512 + line * 64 + offset % 64 fits in offset width plus three
    localparam int DST_W  = OFF_W + 3;
    localparam int SWEEP  = (MAP_BYTES > tcbg_pkg::ROM_BYTES) ? MAP_BYTES : tcbg_pkg::ROM_BYTES;
    localparam int CLR_W  = $clog2(SWEEP);
    localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(SWEEP - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUB,
        ST_COPY,
        ST_DRAIN,
        ST_MREAD,
        ST_LAUNCH,
        ST_MASK
    } state_t;

    // memories
    logic [7:0] rom_mem [tcbg_pkg::ROM_BYTES];
    logic [7:0] map_mem [MAP_BYTES];

    // control
    state_t           state_reg;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [2:0]       line_reg;
    logic [2:0]       wr_line_reg;
    logic             wr_pend_reg;
    logic             done_reg;
    logic [7:0]       lit_mask_reg;
    logic [7:0]       map_byte_reg;

    // configuration
    logic [15:0]        screen_base_reg;
    tcbg_pkg::window_t  win_reg;

    // command payload
    logic [15:0]      addr_reg;
    logic [7:0]       code_reg;
    logic [12:0]      idx_reg;
    logic [OFF_W-1:0] offset_reg;
    logic [7:0]       rom_q_reg;
    logic [7:0]       map_q_reg;
    logic             map_hit_reg;

    // datapath
    logic                 accept;
    logic [15:0]          offset16;
    logic                 on_screen;
    logic [DST_W-1:0]     dst;
    logic [31:0]          dst_wide;
    logic                 dst_ok;
    logic [31:0]          rd_wide;
    logic                 clr_in_map;
    logic                 clr_in_rom;
    logic                 win_load;
    logic                 win_done;
    logic [7:0]           win_mask;
    logic [7:0]           win_byte;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    // config is taken at any time; it only changes while idle by contract
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_base_reg <= tcbg_pkg::SCREEN_BASE_RST;
            win_reg.start_x <= tcbg_pkg::WIN_START_RST;
            win_reg.end_x   <= tcbg_pkg::WIN_END_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tcbg_pkg::REG_SCREEN_BASE: screen_base_reg <= cfg_data;
                tcbg_pkg::REG_WIN_START:   win_reg.start_x <= cfg_data[9:0];
                tcbg_pkg::REG_WIN_END:     win_reg.end_x   <= cfg_data[9:0];
                default:                   ;
            endcase
        end
    end

    // cell offset from the screen base, modulo 2^16
    assign offset16  = addr_reg - screen_base_reg;
    assign on_screen = 32'(offset16) < 32'(SCREEN_CELLS);

    // target of the glyph line being written: row of cells, line, column
    assign dst = (DST_W'(offset_reg >> 6) << 9)
               | (DST_W'(wr_line_reg) << 6)
               | DST_W'(offset_reg[5:0]);
    assign dst_wide = 32'(dst);
    assign dst_ok   = dst_wide < 32'(MAP_BYTES);

    // scanout address; beyond the bitmap reads as zero
    assign rd_wide = 32'(idx_reg);

    assign clr_in_map = 32'(clr_cnt_reg) < 32'(MAP_BYTES);
    assign clr_in_rom = 32'(clr_cnt_reg) < 32'(tcbg_pkg::ROM_BYTES);

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            line_reg     <= 3'd0;
            wr_line_reg  <= 3'd0;
            wr_pend_reg  <= 1'b0;
            done_reg     <= 1'b0;
            lit_mask_reg <= 8'd0;
            map_byte_reg <= 8'd0;
        end
        else
        begin
            done_reg    <= 1'b0;
            wr_pend_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (kind)
                            tcbg_pkg::KIND_WRITE: state_reg <= ST_SUB;
                            tcbg_pkg::KIND_READ:  state_reg <= ST_MREAD;
                            default:              state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SUB:
                begin
                    line_reg  <= 3'd0;
                    state_reg <= on_screen ? ST_COPY : ST_IDLE;
                end
                ST_COPY:
                begin
                    // rom read of this line overlaps the bitmap write of the last one
                    wr_line_reg <= line_reg;
                    wr_pend_reg <= 1'b1;
                    line_reg    <= line_reg + 3'd1;
                    if (line_reg == 3'd7)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_MREAD:
                begin
                    state_reg <= ST_LAUNCH;
                end
                ST_LAUNCH:
                begin
                    map_byte_reg <= win_byte;
                    state_reg    <= ST_MASK;
                end
                ST_MASK:
                begin
                    if (win_done)
                    begin
                        lit_mask_reg <= win_mask;
                        done_reg     <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // command capture and offset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= cpu_address;
            code_reg <= char_code;
            idx_reg  <= map_index;
        end
        if (state_reg == ST_SUB)
        begin
            offset_reg <= offset16[OFF_W-1:0];
        end
    end

    // character rom: clearing pass, byte loads, glyph line reads
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (clr_in_rom)
            begin
                rom_mem[clr_cnt_reg[tcbg_pkg::ROM_AW-1:0]] <= 8'hFF;
            end
        end
        else if (accept && (kind == tcbg_pkg::KIND_LOAD))
        begin
            rom_mem[rom_index] <= rom_byte;
        end
        if (state_reg == ST_COPY)
        begin
            rom_q_reg <= rom_mem[{code_reg, line_reg}];
        end
    end

    // bitmap: clearing pass, glyph line writes, scanout reads
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            if (clr_in_map)
            begin
                map_mem[clr_cnt_reg[MAP_AW-1:0]] <= 8'h00;
            end
        end
        else if (wr_pend_reg && dst_ok)
        begin
            map_mem[dst_wide[MAP_AW-1:0]] <= rom_q_reg;
        end
        if (state_reg == ST_MREAD)
        begin
            map_q_reg   <= map_mem[rd_wide[MAP_AW-1:0]];
            map_hit_reg <= rd_wide < 32'(MAP_BYTES);
        end
    end

    assign win_byte = map_hit_reg ? map_q_reg : 8'h00;
    assign win_load = (state_reg == ST_LAUNCH);

    // serial pixel window test
    tcbg_window_unit u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (win_load),
        .pix_byte (win_byte),
        .base_x   ({idx_reg[5:0], 3'b000}),
        .win      (win_reg),
        .done     (win_done),
        .mask     (win_mask)
    );

    // result ports; coordinates follow the captured index
    assign done     = done_reg;
    assign map_byte = map_byte_reg;
    assign pixel_x  = {idx_reg[5:0], 3'b000};
    assign pixel_y  = idx_reg[12:6];
    assign lit_mask = lit_mask_reg;

    // checks
    logic [7:0] map_rev;
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            map_rev[i] = map_byte_reg[7 - i];
        end
    end

    // a result only comes out of the mask wait
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_MASK))
        else $error("result strobe without a scanout read");

    // a lit pixel must be a set bit of the byte
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((lit_mask & ~map_rev) == 8'd0))
        else $error("lit mask has a pixel that is not set");

    // the block is free again when the result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result strobe is high");

    // glyph writes only during the copy sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_pend_reg |-> (state_reg == ST_COPY || state_reg == ST_DRAIN))
        else $error("bitmap write outside a character write");

endmodule

// ===== tb/sv/tb_text_character_bitmap_generator_top.sv =====
module tb_text_character_bitmap_generator_top;

    timeunit 1ns;
    timeprecision 1ps;

    // geometry of the instance under test
    localparam int SCREEN_SIZE = 1024;
    localparam int MAP_SIZE    = 8192;
    localparam int ROW_STRIDE  = 512;

    // codes the package leaves out, both must be ignored by the block
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    // a character write keeps the block busy and gives no result,
    // a scanout read ends with a done strobe
    localparam int SETTLE_CYCLES  = 16;
    // covers the clearing pass after reset and the longest sender gap
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int PHASE_ITEMS    = 280;
    localparam int PHASE_COUNT    = 6;

    typedef struct {
        logic [7:0] map_byte;
        logic [8:0] pixel_x;
        logic [6:0] pixel_y;
        logic [7:0] lit_mask;
    } readout_t;

    // mirrors the rom, the bitmap and the registers; predicts every scanout read
    class bitmap_scoreboard;
        logic [7:0]  glyph_rom [tcbg_pkg::ROM_BYTES];
        logic [7:0]  pixel_map [MAP_SIZE];
        logic [15:0] screen_base;
        logic [9:0]  win_start;
        logic [9:0]  win_end;
        readout_t    expected_readouts[$];
        int          mismatches;
        int          readouts_checked;

        function new();
            foreach (glyph_rom[i]) glyph_rom[i] = 8'hFF;
            foreach (pixel_map[i]) pixel_map[i] = 8'h00;
            screen_base      = tcbg_pkg::SCREEN_BASE_RST;
            win_start        = tcbg_pkg::WIN_START_RST;
            win_end          = tcbg_pkg::WIN_END_RST;
            mismatches       = 0;
            readouts_checked = 0;
        endfunction

        function int pending();
            return expected_readouts.size();
        endfunction

        function void note_config(logic [1:0] idx, logic [15:0] data);
            case (idx)
                tcbg_pkg::REG_SCREEN_BASE: screen_base = data;
                tcbg_pkg::REG_WIN_START:   win_start = data[9:0];
                tcbg_pkg::REG_WIN_END:     win_end = data[9:0];
                default:                   ;
            endcase
        endfunction

        // returns 0 when the block is expected to ignore the transaction
        function bit note_command(logic [1:0] k, logic [15:0] addr, logic [7:0] code,
                                  logic [10:0] ridx, logic [7:0] rbyte, logic [12:0] midx);
            logic [15:0] ofs;
            int          dst;
            readout_t    r;
            case (k)
                tcbg_pkg::KIND_WRITE:
                begin
                    ofs = addr - screen_base;
                    if (ofs >= SCREEN_SIZE)
                        return 0;
                    for (int line = 0; line < 8; line++)
                    begin
                        dst = int'(ofs >> 6) * ROW_STRIDE + line * 64 + int'(ofs[5:0]);
                        if (dst < MAP_SIZE)
                            pixel_map[dst] = glyph_rom[int'(code) * 8 + line];
                    end
                    return 1;
                end
                tcbg_pkg::KIND_LOAD:
                begin
                    glyph_rom[ridx] = rbyte;
                    return 1;
                end
                tcbg_pkg::KIND_READ:
                begin
                    r.map_byte = (int'(midx) < MAP_SIZE) ? pixel_map[midx] : 8'h00;
                    r.pixel_x  = {midx[5:0], 3'b000};
                    r.pixel_y  = midx[12:6];
                    r.lit_mask = 8'h00;
                    for (int i = 0; i < 8; i++)
                        if (r.map_byte[7 - i] && (int'(r.pixel_x) + i) >= int'(win_start)
                            && (int'(r.pixel_x) + i) < int'(win_end))
                            r.lit_mask[i] = 1'b1;
                    expected_readouts.push_back(r);
                    return 1;
                end
                default:
                    return 0;
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_readout(logic [7:0] mb, logic [8:0] px, logic [6:0] py,
                                    logic [7:0] lm);
            readout_t r;
            if (expected_readouts.size() == 0)
            begin
                $display("%0t: readout with none expected, expected nothing actual byte 0x%0h",
                         $time, mb);
                mismatches++;
                return;
            end
            r = expected_readouts.pop_front();
            readouts_checked++;
            compare_field("map_byte", 16'(r.map_byte), 16'(mb));
            compare_field("pixel_x", 16'(r.pixel_x), 16'(px));
            compare_field("pixel_y", 16'(r.pixel_y), 16'(py));
            compare_field("lit_mask", 16'(r.lit_mask), 16'(lm));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [15:0] cpu_address;
    logic [7:0]  char_code;
    logic [10:0] rom_index;
    logic [7:0]  rom_byte;
    logic [12:0] map_index;
    logic        done;
    logic [7:0]  map_byte;
    logic [8:0]  pixel_x;
    logic [6:0]  pixel_y;
    logic [7:0]  lit_mask;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    bitmap_scoreboard sb;

    // stimulus bookkeeping
    logic [7:0]  last_glyph_code;
    logic [9:0]  last_cell;
    int          quiet_left;
    int          useful_items;
    int          n_writes;
    int          n_loads;
    int          n_reads;
    int          n_ignored;
    int          n_settings;
    logic [15:0] base_set [PHASE_COUNT];
    logic [9:0]  ws_set [PHASE_COUNT];
    logic [9:0]  we_set [PHASE_COUNT];

    text_character_bitmap_generator_top #(
        .SCREEN_CELLS(SCREEN_SIZE),
        .MAP_BYTES   (MAP_SIZE)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .cpu_address(cpu_address),
        .char_code  (char_code),
        .rom_index  (rom_index),
        .rom_byte   (rom_byte),
        .map_index  (map_index),
        .done       (done),
        .map_byte   (map_byte),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .lit_mask   (lit_mask),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: the strobe is taken at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            sb.check_readout(map_byte, pixel_x, pixel_y, lit_mask);
    end

    // watchdog: any accepted transaction on any channel restarts the count
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && busy === 1'b0) || done === 1'b1
                || (cfg_valid && cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // called just after a rising edge; returns just after the accepting edge
    // with start still high, so a back-to-back transaction keeps it up
    task automatic issue_command(logic [1:0] k, logic [15:0] addr, logic [7:0] code,
                                 logic [10:0] ridx, logic [7:0] rbyte, logic [12:0] midx);
        bit acted;
        start       <= 1'b1;
        kind        <= k;
        cpu_address <= addr;
        char_code   <= code;
        rom_index   <= ridx;
        rom_byte    <= rbyte;
        map_index   <= midx;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        acted = sb.note_command(k, addr, code, ridx, rbyte, midx);
        if (!acted)
            n_ignored++;
        else
        begin
            useful_items++;
            case (k)
                tcbg_pkg::KIND_WRITE: n_writes++;
                tcbg_pkg::KIND_LOAD:  n_loads++;
                default:              n_reads++;
            endcase
        end
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // sender holds off until every scanout read has come back
    task automatic wait_for_readouts();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_register(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        sb.note_config(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly well-formed traffic: glyph loads, writes inside the screen that
    // copy the glyph just loaded, reads aimed at the cell just written
    task automatic random_command();
        logic [1:0]  k;
        logic [15:0] addr;
        logic [7:0]  code;
        logic [7:0]  rbyte;
        logic [10:0] ridx;
        logic [12:0] midx;
        logic [9:0]  screen_pos;
        int          pick;
        addr       = 16'($urandom);
        code       = 8'($urandom);
        ridx       = 11'($urandom);
        rbyte      = 8'($urandom);
        midx       = 13'($urandom);
        screen_pos = 10'($urandom);
        pick       = $urandom_range(0, 99);
        if (pick < 28)
        begin
            k = tcbg_pkg::KIND_LOAD;
            last_glyph_code = ridx[10:3];
        end
        else if (pick < 55)
        begin
            k = tcbg_pkg::KIND_WRITE;
            if ($urandom_range(0, 1) == 1)
                code = last_glyph_code;
            // the rest are addresses anywhere, mostly off screen
            if ($urandom_range(0, 99) < 85)
            begin
                addr      = sb.screen_base + 16'(screen_pos);
                last_cell = screen_pos;
            end
        end
        else if (pick < 96)
        begin
            k = tcbg_pkg::KIND_READ;
            if ($urandom_range(0, 99) < 70)
                midx = 13'(int'(last_cell >> 6) * ROW_STRIDE + $urandom_range(0, 7) * 64
                           + int'(last_cell[5:0]));
        end
        else
            k = KIND_UNUSED;
        issue_command(k, addr, code, ridx, rbyte, midx);
    endtask

    initial
    begin
        sb = new();
        last_glyph_code = 8'd0;
        last_cell       = 10'd0;
        quiet_left      = 0;
        useful_items    = 0;
        n_writes        = 0;
        n_loads         = 0;
        n_reads         = 0;
        n_ignored       = 0;
        n_settings      = 1;

        // register settings per phase: base extremes, offset and empty
        // windows, a window wider than the bitmap, a random window and an empty one past the bitmap
        base_set[0] = 16'h0000;          ws_set[0] = 10'd0;    we_set[0] = 10'd512;
        base_set[1] = 16'hFFFF;          ws_set[1] = 10'd3;    we_set[1] = 10'd509;
        base_set[2] = 16'($urandom);     ws_set[2] = 10'd300;  we_set[2] = 10'd200;
        base_set[3] = tcbg_pkg::SCREEN_BASE_RST;
        ws_set[3]   = 10'd0;
        we_set[3]   = 10'd1023;
        base_set[4] = 16'($urandom);
        ws_set[4]   = 10'($urandom_range(0, 520));
        we_set[4]   = 10'($urandom_range(0, 520));
        base_set[5] = 16'h8000;          ws_set[5] = 10'd1023; we_set[5] = 10'd1023;

        start       <= 1'b0;
        kind        <= tcbg_pkg::KIND_WRITE;
        cpu_address <= 16'd0;
        char_code   <= 8'd0;
        rom_index   <= 11'd0;
        rom_byte    <= 8'd0;
        map_index   <= 13'd0;
        cfg_valid   <= 1'b0;
        cfg_index   <= tcbg_pkg::REG_SCREEN_BASE;
        cfg_data    <= 16'd0;
        rst_n       <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset register values; the first transaction
        // waits out the clearing pass
        // bitmap starts at zero, both ends of the index range
        issue_command(tcbg_pkg::KIND_READ, 16'hFFFF, 8'hFF, 11'h7FF, 8'hFF, 13'd0);
        issue_command(tcbg_pkg::KIND_READ, 16'h0000, 8'h00, 11'h000, 8'h00, 13'd8191);
        // glyph from an untouched rom is all ones
        issue_command(tcbg_pkg::KIND_WRITE, tcbg_pkg::SCREEN_BASE_RST, 8'h00, 11'h000, 8'h00,
                      13'd0);
        issue_command(tcbg_pkg::KIND_READ, 16'h0000, 8'h00, 11'h000, 8'h00, 13'd0);
        issue_command(tcbg_pkg::KIND_READ, 16'h0000, 8'h00, 11'h000, 8'h00, 13'd448);
        // rom loads at both ends of the index range, full glyph of code 255
        issue_command(tcbg_pkg::KIND_LOAD, 16'h0000, 8'h00, 11'd0, 8'hA5, 13'd0);
        for (int line = 0; line < 8; line++)
            issue_command(tcbg_pkg::KIND_LOAD, 16'($urandom), 8'($urandom), 11'(2040 + line),
                          (line == 0) ? 8'h00 : (line == 7) ? 8'hFF : 8'(8'h81 >> line),
                          13'($urandom));
        // last cell of the screen lands on the last bitmap byte
        issue_command(tcbg_pkg::KIND_WRITE, tcbg_pkg::SCREEN_BASE_RST + 16'(SCREEN_SIZE - 1),
                      8'hFF, 11'h000, 8'h00, 13'd0);
        issue_command(tcbg_pkg::KIND_READ, 16'h0000, 8'h00, 11'h000, 8'h00, 13'd8191);
        issue_command(tcbg_pkg::KIND_READ, 16'h0000, 8'h00, 11'h000, 8'h00, 13'd7743);
        // writes off screen: just past the end, just before the base, address extremes
        issue_command(tcbg_pkg::KIND_WRITE, tcbg_pkg::SCREEN_BASE_RST + 16'(SCREEN_SIZE),
                      8'h00, 11'h000, 8'h00, 13'd0);
        issue_command(tcbg_pkg::KIND_WRITE, tcbg_pkg::SCREEN_BASE_RST - 16'd1, 8'h00,
                      11'h000, 8'h00, 13'd0);
        issue_command(tcbg_pkg::KIND_WRITE, 16'h0000, 8'hFF, 11'h000, 8'h00, 13'd0);
        issue_command(tcbg_pkg::KIND_WRITE, 16'hFFFF, 8'h00, 11'h000, 8'h00, 13'd0);
        // glyph from a loaded rom line
        issue_command(tcbg_pkg::KIND_WRITE, tcbg_pkg::SCREEN_BASE_RST + 16'd1, 8'h00,
                      11'h000, 8'h00, 13'd0);
        issue_command(tcbg_pkg::KIND_READ, 16'h0000, 8'h00, 11'h000, 8'h00, 13'd1);
        // unused kind is dropped whatever the fields
        issue_command(KIND_UNUSED, 16'hFFFF, 8'hFF, 11'h7FF, 8'hFF, 13'h1FFF);
        issue_command(KIND_UNUSED, 16'h0000, 8'h00, 11'h000, 8'h00, 13'h0000);

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            // registers change only with the block idle
            wait_for_readouts();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_register(tcbg_pkg::REG_SCREEN_BASE, base_set[phase]);
            write_register(tcbg_pkg::REG_WIN_START, {6'($urandom), ws_set[phase]});
            write_register(tcbg_pkg::REG_WIN_END, {6'($urandom), we_set[phase]});
            if (phase == 0 || phase == 3)
                write_register(REG_UNUSED, 16'($urandom));
            n_settings++;

            useful_items = 0;
            while (useful_items < PHASE_ITEMS)
            begin
                random_command();
                // now and then the sender lets the pipe run dry
                if ($urandom_range(0, 199) == 0)
                    wait_for_readouts();
                else
                    pause_sender(pick_gap());
            end
        end

        wait_for_readouts();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d character writes, %0d rom loads, %0d scanout reads, %0d ignored",
                 n_writes, n_loads, n_reads, n_ignored);
        $display("%0d readouts checked over %0d register settings, %0d mismatches",
                 sb.readouts_checked, n_settings, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tcbg_pkg.sv
rtl/core/tcbg_window_unit.sv
rtl/core/text_character_bitmap_generator_top.sv
tb/sv/tb_text_character_bitmap_generator_top.sv
